FILE: sv/aset_pkg.sv
// Shared constants, codes, types and helpers of the audio saliency event detector.
package aset_pkg;

    // Port widths
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 120;

    // Bit places of the detection flags in m_tdata
    localparam int unsigned OUT_SPEECH_BIT = 82;
    localparam int unsigned OUT_LOUD_BIT   = 83;

    // Noise floor: minimum in Q0.24, start value in Q0.16
    localparam logic [23:0] FLOOR_MIN      = 24'd83886;
    localparam logic [15:0] FLOOR_INIT_Q16 = 16'd328;

    // Detection thresholds
    localparam logic [15:0] ZCR_LOW    = 16'd2294;
    localparam logic [15:0] ZCR_HIGH   = 16'd20971;
    localparam logic [23:0] SPEECH_MIN = 24'd754974;
    localparam logic [23:0] LOUD_MIN   = 24'd11744051;

    // Habituation windows (ms) and angles (Q7.8 degrees)
    localparam logic [31:0] HAB_STRONG_MS  = 32'd1800;
    localparam logic [31:0] HAB_WEAK_MS    = 32'd2800;
    localparam logic [16:0] HAB_STRONG_DEG = 17'd4608;
    localparam logic [16:0] HAB_WEAK_DEG   = 17'd7680;

    // Azimuth: full scale 75 degrees in Q7.8, muted at or below this energy sum
    localparam logic [14:0] AZ_FULL    = 15'd19200;
    localparam logic [16:0] AZ_MIN_SUM = 17'd65;

    // direction_x = az * 64 / 45, rounded
    localparam logic [31:0] DX_RND = 32'd22;
    localparam logic [16:0] DX_DEN = 17'd45;
    localparam logic [14:0] DX_MAX = 15'd32767;

    // strength = sum * 27 / 40, truncated
    localparam logic [31:0] ST_MUL  = 32'd27;
    localparam logic [16:0] ST_DEN  = 17'd40;
    localparam logic [15:0] ST_FULL = 16'hFFFF;

    // Floor adaptation divisors (rise / fall)
    localparam logic [16:0] FL_DEN_UP = 17'd200;
    localparam logic [16:0] FL_DEN_DN = 17'd50;

    // Event codes
    typedef logic [2:0] evt_code_t;
    localparam evt_code_t EVT_NONE  = 3'd0;
    localparam evt_code_t EVT_LOUD  = 3'd1;
    localparam evt_code_t EVT_START = 3'd2;
    localparam evt_code_t EVT_DIR   = 3'd3;
    localparam evt_code_t EVT_END   = 3'd4;

    // Habituation codes
    localparam logic [1:0] HAB_NONE   = 2'd0;
    localparam logic [1:0] HAB_WEAK   = 2'd1;
    localparam logic [1:0] HAB_STRONG = 2'd2;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_FLOOR  = 2'd0;
    localparam cfg_idx_t REG_MAX_EV = 2'd1;

    // Divider request: remainder seed, left-aligned numerator rest, divisor, cycles
    typedef struct packed {
        logic        start;
        logic [16:0] rem;
        logic [31:0] nq;
        logic [16:0] den;
        logic [3:0]  ncyc;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

    // Everything the output side needs for one window
    typedef struct packed {
        evt_code_t [2:0] types;
        logic [1:0]      count;
        logic [15:0]     strength;
        logic [15:0]     dir_x;
        logic [15:0]     level;
        logic [15:0]     floor_q16;
        logic [15:0]     azimuth;
        logic [1:0]      hab;
        logic            speech;
        logic            loud;
        logic [31:0]     stamp;
    } win_rec_t;

    // Q0.16 start value to Q0.24 floor, held at the minimum
    function automatic logic [23:0] load_floor(input logic [15:0] q16);
        logic [23:0] f;
        f = {q16, 8'd0};
        return (f < FLOOR_MIN) ? FLOOR_MIN : f;
    endfunction

endpackage

FILE: sv/aset_div.sv
// Shared restoring divider, two quotient bits per cycle.
module aset_div import aset_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [16:0] rem_reg, rem_next;
    logic [31:0] nq_reg, nq_next;
    logic [16:0] den_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [17:0] t1, t2;
    logic        ge1, ge2;
    logic [16:0] r1;

    always_comb begin
        t1       = {rem_reg, nq_reg[31]};
        ge1      = t1 >= {1'b0, den_reg};
        r1       = ge1 ? 17'(t1 - {1'b0, den_reg}) : t1[16:0];
        t2       = {r1, nq_reg[30]};
        ge2      = t2 >= {1'b0, den_reg};
        rem_next = ge2 ? 17'(t2 - {1'b0, den_reg}) : t2[16:0];
        nq_next  = {nq_reg[29:0], ge1, ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= req.rem;
                nq_reg   <= req.nq;
                den_reg  <= req.den;
                cnt_reg  <= req.ncyc;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                nq_reg  <= nq_next;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient sits in the low bits once all shifts are done
    assign rsp.done = done_reg;
    assign rsp.quot = nq_reg;

endmodule

FILE: sv/aset_seq.sv
// Per-window sequencer: detection, divider schedule, habituation, detector state.
module aset_seq import aset_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_left,
    input  logic [15:0] in_right,
    input  logic [15:0] in_zcr,
    input  logic [31:0] in_stamp,
    input  logic        clr,
    input  logic [15:0] clr_value,
    input  logic [1:0]  cap,
    output logic        rec_valid,
    input  logic        rec_ready,
    output win_rec_t    rec
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_AZ, S_DX, S_ST, S_FL, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic   go_reg;

    // detector state
    logic [23:0] floor_reg;
    logic [15:0] prev_az_reg;
    logic [31:0] prev_time_reg;
    logic        was_reg;

    // window work registers
    logic [16:0] sum_reg;
    logic [15:0] absd_reg;
    logic        neg_reg;
    logic [15:0] zcr_reg;
    logic [31:0] ts_reg;
    logic [30:0] mag_reg;
    logic        speech_reg, loud_reg, hi5_reg;
    logic [14:0] azmag_reg, dmag_reg;
    logic [15:0] st_reg;
    win_rec_t    rec_reg;

    div_req_t req;
    div_rsp_t rsp;

    aset_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // level compares, Q0.24
    logic [23:0] lvl;
    logic [26:0] lvl5, fl5, fl8;
    logic [27:0] fl13;
    logic        band, speech_c, loud_c, hi5_c;
    logic [30:0] mag_c;

    always_comb begin
        lvl      = {sum_reg, 7'd0};
        lvl5     = 27'(lvl) + 27'({lvl, 2'b00});
        fl5      = 27'(floor_reg) + 27'({floor_reg, 2'b00});
        fl8      = {floor_reg, 3'b000};
        fl13     = 28'(floor_reg) + 28'({floor_reg, 2'b00}) + 28'({floor_reg, 3'b000});
        band     = (zcr_reg >= ZCR_LOW) && (zcr_reg <= ZCR_HIGH);
        speech_c = band && (28'(lvl5) > fl13) && (lvl > SPEECH_MIN);
        loud_c   = (lvl > LOUD_MIN) && (27'(lvl) > fl8);
        hi5_c    = 27'(lvl) > fl5;
        mag_c    = 31'(absd_reg) * 31'(AZ_FULL);
    end

    // divider operands per step; num < den * 2^(2*ncyc) holds for each
    logic [31:0] num;
    logic        fl_up;

    always_comb begin
        fl_up     = lvl > floor_reg;
        num       = '0;
        req       = '0;
        req.start = go_reg;
        case (state_reg)
            S_AZ: begin
                num      = {1'b0, mag_reg} + 32'(sum_reg[16:1]);
                req.rem  = 17'(num >> 16);
                req.nq   = num << 16;
                req.den  = sum_reg;
                req.ncyc = 4'd8;
            end
            S_DX: begin
                num      = 32'({azmag_reg, 6'd0}) + DX_RND;
                req.rem  = 17'(num >> 16);
                req.nq   = num << 16;
                req.den  = DX_DEN;
                req.ncyc = 4'd8;
            end
            S_ST: begin
                num      = 32'(sum_reg) * ST_MUL;
                req.rem  = 17'(num >> 18);
                req.nq   = num << 14;
                req.den  = ST_DEN;
                req.ncyc = 4'd9;
            end
            S_FL: begin
                if (fl_up) begin
                    num     = 32'(lvl - floor_reg) + 32'(FL_DEN_UP >> 1);
                    req.den = FL_DEN_UP;
                end else begin
                    num     = 32'(floor_reg - lvl) + 32'(FL_DEN_DN >> 1);
                    req.den = FL_DEN_DN;
                end
                req.rem  = 17'(num >> 20);
                req.nq   = num << 12;
                req.ncyc = 4'd10;
            end
            default: ;
        endcase
    end

    // quotient post-processing
    logic [14:0] az_q_c, dx_q_c;
    logic [15:0] st_q_c;
    logic [23:0] fl_raw, fl_adj;

    always_comb begin
        if (sum_reg > AZ_MIN_SUM) begin
            az_q_c = (rsp.quot > 32'(AZ_FULL)) ? AZ_FULL : rsp.quot[14:0];
        end else begin
            az_q_c = '0;
        end
        dx_q_c = (rsp.quot > 32'(DX_MAX)) ? DX_MAX : rsp.quot[14:0];
        st_q_c = (rsp.quot > 32'(ST_FULL)) ? ST_FULL : rsp.quot[15:0];
        if (fl_up) begin
            fl_raw = 24'(32'(floor_reg) + rsp.quot);
        end else if (rsp.quot > 32'(floor_reg)) begin
            fl_raw = '0;
        end else begin
            fl_raw = 24'(32'(floor_reg) - rsp.quot);
        end
        fl_adj = (fl_raw < FLOOR_MIN) ? FLOOR_MIN : fl_raw;
    end

    // habituation and event list
    logic [15:0] az_c, dx_c;
    logic [16:0] dd, absdd;
    logic [31:0] since;
    logic        salient, seen, strong_c, weak_c, res_sal, started, ended;
    evt_code_t [2:0] ty;
    logic [1:0]  cnt, n;
    win_rec_t    rec_c;

    always_comb begin
        az_c    = neg_reg ? 16'(16'd0 - 16'(azmag_reg)) : 16'(azmag_reg);
        dx_c    = neg_reg ? 16'(16'd0 - 16'(dmag_reg)) : 16'(dmag_reg);
        dd      = 17'($signed({az_c[15], az_c}) - $signed({prev_az_reg[15], prev_az_reg}));
        absdd   = dd[16] ? 17'(17'd0 - dd) : dd;
        since   = ts_reg - prev_time_reg;
        salient = speech_reg || loud_reg;
        seen    = prev_time_reg != 32'd0;
        strong_c = salient && seen && (since < HAB_STRONG_MS) && (absdd < HAB_STRONG_DEG);
        weak_c   = salient && !strong_c && seen && (since < HAB_WEAK_MS)
                   && (absdd < HAB_WEAK_DEG);
        res_sal = strong_c ? (loud_reg || hi5_reg) : salient;
        started = speech_reg && !was_reg;
        ended   = !speech_reg && was_reg;

        ty  = {3{EVT_NONE}};
        cnt = 2'd0;
        if (loud_reg) begin
            ty[0] = EVT_LOUD;
            cnt   = 2'd1;
        end else begin
            if (started) begin
                ty[cnt] = EVT_START;
                cnt     = cnt + 2'd1;
            end
            if (res_sal && speech_reg) begin
                ty[cnt] = EVT_DIR;
                cnt     = cnt + 2'd1;
            end
            if (ended) begin
                ty[cnt] = EVT_END;
                cnt     = cnt + 2'd1;
            end
        end
        n = (cnt > cap) ? cap : cnt;
        if (n == 2'd0) begin
            n = 2'd1;   // lone telemetry item, ty[0] is already none
        end

        rec_c.types     = ty;
        rec_c.count     = n;
        rec_c.strength  = st_reg;
        rec_c.dir_x     = dx_c;
        rec_c.level     = sum_reg[16:1];
        rec_c.floor_q16 = floor_reg[23:8];
        rec_c.azimuth   = az_c;
        rec_c.hab       = strong_c ? HAB_STRONG : (weak_c ? HAB_WEAK : HAB_NONE);
        rec_c.speech    = speech_reg;
        rec_c.loud      = loud_reg;
        rec_c.stamp     = ts_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            floor_reg     <= load_floor(FLOOR_INIT_Q16);
            prev_az_reg   <= '0;
            prev_time_reg <= '0;
            was_reg       <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (clr) begin
                        floor_reg     <= load_floor(clr_value);
                        prev_az_reg   <= '0;
                        prev_time_reg <= '0;
                        was_reg       <= 1'b0;
                    end
                    if (in_valid) begin
                        sum_reg   <= 17'(in_left) + 17'(in_right);
                        absd_reg  <= (in_right >= in_left) ? 16'(in_right - in_left)
                                                           : 16'(in_left - in_right);
                        neg_reg   <= in_right < in_left;
                        zcr_reg   <= in_zcr;
                        ts_reg    <= in_stamp;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    mag_reg    <= mag_c;
                    speech_reg <= speech_c;
                    loud_reg   <= loud_c;
                    hi5_reg    <= hi5_c;
                    go_reg     <= 1'b1;
                    state_reg  <= S_AZ;
                end
                S_AZ: begin
                    if (rsp.done) begin
                        azmag_reg <= az_q_c;
                        go_reg    <= 1'b1;
                        state_reg <= S_DX;
                    end
                end
                S_DX: begin
                    if (rsp.done) begin
                        dmag_reg  <= dx_q_c;
                        go_reg    <= 1'b1;
                        state_reg <= S_ST;
                    end
                end
                S_ST: begin
                    if (rsp.done) begin
                        st_reg <= st_q_c;
                        // floor only adapts on quiet windows
                        if (salient) begin
                            state_reg <= S_FIN;
                        end else begin
                            go_reg    <= 1'b1;
                            state_reg <= S_FL;
                        end
                    end
                end
                S_FL: begin
                    if (rsp.done) begin
                        floor_reg <= fl_adj;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    rec_reg <= rec_c;
                    if (res_sal) begin
                        prev_time_reg <= ts_reg;
                        prev_az_reg   <= az_c;
                    end
                    was_reg   <= speech_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (rec_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign rec_valid = state_reg == S_OUT;
    assign rec       = rec_reg;

endmodule

FILE: sv/audio_saliency_event_detector_unit.sv
// Top level of the audio saliency event detector: ports, config registers, result stream.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: left, right, crossing rate, stamp
//  m_      | out | m_tvalid/m_tready  | m_tdata telemetry, m_tuser type, m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// The time from accepting a window to its first result is set by the shared divider:
// azimuth, direction, strength and floor step run through it one after another at
// two quotient bits a cycle; a salient window keeps its floor and skips the floor step.
// Each window yields one to three result items on m_, one per cycle while not stalled.
// The next item is taken while results of the previous one still drain; a stalled
// m_ side holds the finished window in the sequencer until the result register frees.
// Synchronous active-low reset; no clearing pass is needed.
module audio_saliency_event_detector_unit import aset_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] left_energy, [31:16] right_energy, [47:32] crossing_rate,
    // [79:48] timestamp_ms
    input  logic [S_DATA_W-1:0] s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [15:0] strength, [31:16] direction_x, [47:32] level, [63:48] noise_floor_out,
    // [79:64] azimuth, [81:80] habituation, [82] speech_active, [83] loud_noise,
    // [115:84] event_time, [119:116] zero
    output logic [M_DATA_W-1:0] m_tdata,
    // [2:0] event_type
    output logic [2:0]          m_tuser,
    output logic                m_tlast,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_idx_t            cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [1:0] max_ev_reg;
    logic [1:0] cap;
    logic       clr;

    logic       rec_valid, rec_ready;
    win_rec_t   rec;

    // result register and read-out position
    win_rec_t   out_reg;
    logic       pend_reg;
    logic [1:0] idx_reg;
    logic       at_last;
    evt_code_t  cur_type;
    logic [15:0] cur_strength;

    assign cfg_ready = 1'b1;
    // writing the start floor doubles as a detector restart (acted on only while idle)
    assign clr = cfg_valid && cfg_ready && (cfg_index == REG_FLOOR);
    assign cap = (max_ev_reg == 2'd0) ? 2'd1 : max_ev_reg;

    aset_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_left   (s_tdata[15:0]),
        .in_right  (s_tdata[31:16]),
        .in_zcr    (s_tdata[47:32]),
        .in_stamp  (s_tdata[79:48]),
        .clr       (clr),
        .clr_value (cfg_data),
        .cap       (cap),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    assign rec_ready = !pend_reg;
    assign at_last   = 2'(idx_reg + 2'd1) == out_reg.count;
    assign cur_type  = out_reg.types[idx_reg];

    always_comb begin
        case (cur_type)
            EVT_END:  cur_strength = ST_FULL;
            EVT_NONE: cur_strength = '0;
            default:  cur_strength = out_reg.strength;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ev_reg <= 2'd3;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MAX_EV: max_ev_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (rec_valid && rec_ready) begin
                out_reg  <= rec;
                pend_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (pend_reg && m_tready) begin
                if (at_last) begin
                    pend_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    assign m_tvalid = pend_reg;
    assign m_tuser  = cur_type;
    assign m_tlast  = at_last;
    assign m_tdata  = {4'd0, out_reg.stamp, out_reg.loud, out_reg.speech, out_reg.hab,
                       out_reg.azimuth, out_reg.floor_q16, out_reg.level, out_reg.dir_x,
                       cur_strength};

endmodule

FILE: sv/aset_checker.sv
// Port-level checks of the audio saliency event detector, bound to the top level.
module aset_checker import aset_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [2:0]          m_tuser,
    input logic                m_tlast
);

    // one window at a time: ready drops right after an accept
    a_one_window: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata)
                                  && $stable(m_tlast))
        else $error("stalled result item changed");

    // loud noise suppresses every other event of the window
    a_loud_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EVT_LOUD) |-> m_tlast && m_tdata[OUT_LOUD_BIT])
        else $error("loud noise event not alone or flag clear");

    a_none_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EVT_NONE) |-> m_tlast && (m_tdata[15:0] == 16'd0))
        else $error("telemetry item not final or has strength");

    // a reset edge leaves the block empty and ready
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind audio_saliency_event_detector_unit aset_checker u_aset_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the audio saliency event detector unit.
`timescale 1ns / 100ps

module testbench;
    import aset_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 63;

    // One result item as the block should emit it
    typedef struct packed {
        evt_code_t   kind;
        logic [15:0] strength;
        logic [15:0] dir_x;
        logic [15:0] level;
        logic [15:0] floor_q16;
        logic [15:0] azimuth;
        logic [1:0]  hab;
        logic        speech;
        logic        loud;
        logic [31:0] stamp;
        logic        last;
    } event_rec_t;

    // Predicts the event items of each window and compares them against the stream
    class saliency_scoreboard;
        logic [15:0] start_floor;
        logic [1:0]  event_cap;
        logic [23:0] floor_q24;
        int          prev_az;
        logic [31:0] prev_hit_ms;
        bit          speech_prev;
        event_rec_t  expected_events[$];
        int          fails;

        function new();
            start_floor = FLOOR_INIT_Q16;
            event_cap   = 2'd3;
            fails       = 0;
            clear_tracking();
        endfunction

        // Floor reload also drops speech and habituation history
        function void clear_tracking();
            floor_q24   = ({start_floor, 8'd0} < FLOOR_MIN) ? FLOOR_MIN : {start_floor, 8'd0};
            prev_az     = 0;
            prev_hit_ms = '0;
            speech_prev = 1'b0;
        endfunction

        function void apply_reg(cfg_idx_t idx, logic [15:0] value);
            case (idx)
                REG_FLOOR: begin
                    start_floor = value;
                    clear_tracking();
                end
                REG_MAX_EV: event_cap = value[1:0];
                default: ;
            endcase
        endfunction

        // Division rounded to nearest, ties away from zero
        function longint unsigned rdiv(longint unsigned n, longint unsigned d);
            return (n + d / 2) / d;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void note_window(logic [15:0] l, logic [15:0] r, logic [15:0] zcr,
                                  logic [31:0] ts);
            longint unsigned total, lvl, fl, fall_step, mag, q, st, dmag;
            int          az, diff, dd, n, cap;
            logic [31:0] since;
            logic [1:0]  hab;
            logic [15:0] dx;
            bit          band, speech, loud, keep, speech_go, speech_stop;
            evt_code_t   kinds[3];
            logic [15:0] strengths[3];
            event_rec_t  e;

            total = l + r;
            lvl   = total * 128;
            fl    = floor_q24;
            cap   = (event_cap == 0) ? 1 : int'(event_cap);

            band   = zcr >= ZCR_LOW && zcr <= ZCR_HIGH;
            speech = band && lvl * 5 > fl * 13 && lvl > SPEECH_MIN;
            loud   = lvl > LOUD_MIN && lvl > fl * 8;

            // floor tracks only quiet or non-salient windows
            if (!(speech || loud)) begin
                if (lvl > fl) begin
                    fl = fl + rdiv(lvl - fl, FL_DEN_UP);
                end else begin
                    fall_step = rdiv(fl - lvl, FL_DEN_DN);
                    fl = (fall_step > fl) ? 0 : fl - fall_step;
                end
                if (fl < FLOOR_MIN) fl = FLOOR_MIN;
                floor_q24 = 24'(fl);
            end

            az = 0;
            if (total > AZ_MIN_SUM) begin
                diff = int'(r) - int'(l);
                mag  = (diff < 0) ? -diff : diff;
                q    = rdiv(mag * AZ_FULL, total);
                if (q > AZ_FULL) q = AZ_FULL;
                az = (diff < 0) ? -int'(q) : int'(q);
            end

            hab  = HAB_NONE;
            keep = speech || loud;
            if (speech || loud) begin
                since = ts - prev_hit_ms;
                dd    = az - prev_az;
                if (dd < 0) dd = -dd;
                // a stored time of zero reads as no earlier salient window
                if (prev_hit_ms != 0 && since < HAB_STRONG_MS && dd < HAB_STRONG_DEG) begin
                    hab  = HAB_STRONG;
                    keep = loud || lvl > fl * 5;
                end else if (prev_hit_ms != 0 && since < HAB_WEAK_MS && dd < HAB_WEAK_DEG) begin
                    hab = HAB_WEAK;
                end
                if (keep) begin
                    prev_hit_ms = ts;
                    prev_az     = az;
                end
            end
            speech_go   = speech && !speech_prev;
            speech_stop = !speech && speech_prev;
            speech_prev = speech;

            st = total * ST_MUL / ST_DEN;
            if (st > ST_FULL) st = ST_FULL;
            dmag = rdiv(longint'((az < 0) ? -az : az) * 64, DX_DEN);
            if (dmag > DX_MAX) dmag = DX_MAX;
            dx = 16'((az < 0) ? -int'(dmag) : int'(dmag));

            // loud noise masks every speech event
            n = 0;
            if (loud) begin
                kinds[n] = EVT_LOUD; strengths[n] = 16'(st); n++;
            end else begin
                if (speech_go) begin
                    kinds[n] = EVT_START; strengths[n] = 16'(st); n++;
                end
                if (keep && speech) begin
                    kinds[n] = EVT_DIR; strengths[n] = 16'(st); n++;
                end
                if (speech_stop) begin
                    kinds[n] = EVT_END; strengths[n] = ST_FULL; n++;
                end
            end
            if (n > cap) n = cap;
            if (n == 0) begin
                kinds[0] = EVT_NONE; strengths[0] = '0; n = 1;
            end

            for (int k = 0; k < n; k++) begin
                e.kind      = kinds[k];
                e.strength  = strengths[k];
                e.dir_x     = dx;
                e.level     = 16'(total >> 1);
                e.floor_q16 = floor_q24[23:8];
                e.azimuth   = 16'(az);
                e.hab       = hab;
                e.speech    = speech;
                e.loud      = loud;
                e.stamp     = ts;
                e.last      = (k == n - 1);
                expected_events.push_back(e);
            end
        endfunction

        function string show(event_rec_t e);
            return $sformatf({"type=%0d str=%0d dx=%0d lvl=%0d floor=%0d az=%0d hab=%0d",
                              " sp=%0b ld=%0b t=%0d last=%0b"},
                             e.kind, e.strength, $signed(e.dir_x), e.level, e.floor_q16,
                             $signed(e.azimuth), e.hab, e.speech, e.loud, e.stamp, e.last);
        endfunction

        function void check_result(evt_code_t kind, logic [M_DATA_W-1:0] d, logic last);
            event_rec_t got, want;
            got.kind      = kind;
            got.strength  = d[15:0];
            got.dir_x     = d[31:16];
            got.level     = d[47:32];
            got.floor_q16 = d[63:48];
            got.azimuth   = d[79:64];
            got.hab       = d[81:80];
            got.speech    = d[OUT_SPEECH_BIT];
            got.loud      = d[OUT_LOUD_BIT];
            got.stamp     = d[115:84];
            got.last      = last;
            if (expected_events.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected item: %s", show(got));
                return;
            end
            want = expected_events.pop_front();
            // whole-record compare covers every field, X included
            if (got !== want) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch expected: %s", show(want));
                    $display("         actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [2:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_idx_t            cfg_index = REG_FLOOR;
    logic [15:0]         cfg_data  = '0;

    saliency_scoreboard sb;
    int                 cycle_count = 0;
    int                 burst_left  = 0;
    int                 stall_left  = 0;
    bit                 tx_gaps     = 1'b0;
    bit                 rx_stalls   = 1'b0;
    int                 pan         = 50;     // percent of window energy on the right
    logic [31:0]        t_now;

    audio_saliency_event_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure: random stall runs, some longer than one window's latency
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every accepted result item goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Offer one window; bursts of back-to-back items, separated by random gaps when tx_gaps is set
    task automatic send_window(input logic [15:0] l, input logic [15:0] r,
                               input logic [15:0] zcr, input logic [31:0] ts);
        int gap;
        if (burst_left == 0) begin
            gap        = 0;
            burst_left = $urandom_range(1, 6);
            if (tx_gaps)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                                  : $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, zcr, r, l};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        sb.note_window(l, r, zcr, ts);
    endtask

    // Hold off the sender until every expected item has come back
    task automatic drain();
        if (s_tvalid) s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // max_events always written; floor reload optional (it also clears detector state)
    task automatic program_regs(input bit load, input logic [15:0] floor_q16,
                                input logic [1:0] cap);
        logic [15:0] word;
        word = {14'($urandom), cap};    // only the low two bits matter
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_EV;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_reg(REG_MAX_EV, word);
        if (load) begin
            cfg_index <= REG_FLOOR;
            cfg_data  <= floor_q16;
            do @(posedge aclk); while (!cfg_ready);
            sb.apply_reg(REG_FLOOR, floor_q16);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random window: mostly quiet/speech runs with steady direction, plus loud and noise
    task automatic pick_window(output logic [15:0] l, output logic [15:0] r,
                               output logic [15:0] zcr, output logic [31:0] ts);
        int mode, base, lv, rv;
        mode = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) pan = $urandom_range(0, 100);
        zcr = 16'($urandom);
        if (mode < 30) begin
            base = $urandom_range(0, 500);
        end else if (mode < 70) begin
            base = $urandom_range(2000, 25000);
            zcr  = 16'($urandom_range(ZCR_LOW - 20, ZCR_HIGH + 20));
        end else begin
            base = $urandom_range(35000, 65535);
        end
        lv = base * 2 * (100 - pan) / 100;
        rv = base * 2 * pan / 100;
        l  = 16'((lv > 65535) ? 65535 : lv);
        r  = 16'((rv > 65535) ? 65535 : rv);
        if (mode >= 82) begin
            l = 16'($urandom);
            r = 16'($urandom);
        end
        t_now = t_now + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(5, 700));
        ts    = t_now;
    endtask

    initial begin
        logic [15:0] phase_floor[PHASES];
        logic [1:0]  phase_cap[PHASES];
        logic [15:0] l, r, zcr;
        logic [31:0] ts;

        phase_floor = '{16'd328, 16'd0, 16'd65535, 16'd700, 16'd1500, 16'd200};
        phase_cap   = '{2'd3, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3};
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings: extremes, azimuth cutoff, speech, habituation
        send_window(16'd0, 16'd0, 16'd0, 32'd100);              // silence
        send_window(16'hFFFF, 16'd0, 16'd0, 32'd200);           // full left
        send_window(16'd0, 16'hFFFF, 16'hFFFF, 32'd300);        // full right, top crossing rate
        send_window(16'd66, 16'd0, 16'd5000, 32'd400);          // just above azimuth cutoff
        send_window(16'd65, 16'd0, 16'd5000, 32'd500);          // azimuth muted
        send_window(16'd5000, 16'd5000, ZCR_LOW, 32'd1000);     // speech starts
        send_window(16'd5000, 16'd5000, ZCR_HIGH, 32'd1500);    // strong habituation, kept
        send_window(16'd3100, 16'd6900, 16'd10000, 32'd3400);   // weak habituation
        send_window(16'd3000, 16'd7000, 16'd10000, 32'd3450);   // azimuth at the weak angle limit, strongly habituated
        send_window(16'd0, 16'd0, 16'd0, 32'd3600);             // speech ends
        send_window(16'hFFFF, 16'hFFFF, 16'd0, 32'd4000);       // loud, strength saturates
        send_window(16'd60000, 16'd60000, 16'd5000, 32'd4100);  // loud masks speech
        send_window(16'd0, 16'd0, 16'd0, 32'd4200);
        send_window(16'd5000, 16'd5000, 16'd5000, 32'd0);       // salient at time zero
        send_window(16'd5000, 16'd5000, 16'd5000, 32'd100);     // zero stamp read as never
        send_window(16'd5000, 16'd5000, 16'd5000, 32'hFFFF_FF00);
        send_window(16'd5000, 16'd5000, 16'd5000, 32'h0000_0100); // stamp wraps
        drain();

        // Directed, raised floor: habituation that drops the direction item, event caps
        program_regs(1'b1, 16'd1000, 2'd3);
        send_window(16'd4000, 16'd4000, 16'd5000, 32'd1000);
        send_window(16'd4000, 16'd4000, 16'd5000, 32'd1200);    // suppressed by strong habituation
        send_window(16'd4000, 16'd4000, 16'd5000, 32'd2900);
        drain();
        program_regs(1'b0, 16'd0, 2'd1);
        send_window(16'd0, 16'd0, 16'd0, 32'd3000);
        send_window(16'd4000, 16'd4000, 16'd5000, 32'd10000);   // start and direction, cut to one
        drain();
        program_regs(1'b0, 16'd0, 2'd0);                        // zero cap behaves as one
        send_window(16'd0, 16'd0, 16'd0, 32'd11000);
        send_window(16'd4000, 16'd4000, 16'd5000, 32'd20000);
        drain();

        // Random phases; the first runs with no idling on either side
        for (int ph = 0; ph < PHASES; ph++) begin
            program_regs(1'b1, phase_floor[ph], phase_cap[ph]);
            tx_gaps   = (ph != 0 && ph != 3);
            rx_stalls = (ph != 0 && ph != 4);
            t_now     = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) drain();
                pick_window(l, r, zcr, ts);
                send_window(l, r, zcr, ts);
            end
            drain();
        end

        // Catch any stray item after the last expected one
        repeat (60) @(posedge aclk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
